@@ src/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Used by sha256_ctrl, sha256_dp and the top level; depends on nothing else.
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Block geometry
  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_W     = BLOCK_BYTES * 8;
  localparam int COUNT_W     = $clog2(BLOCK_BYTES);
  localparam logic [COUNT_W-1:0] LEN_POS  = COUNT_W'(BLOCK_BYTES - 8);
  localparam logic [COUNT_W-1:0] LAST_POS = COUNT_W'(BLOCK_BYTES - 1);

  // Rounds and digest
  localparam int ROUNDS  = 64;
  localparam int ROUND_W = $clog2(ROUNDS);
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
  localparam int DIGEST_WORDS = 8;
  localparam int WIDX_W = $clog2(DIGEST_WORDS);
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(DIGEST_WORDS - 1);

  // Operation codes of the input transaction
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // What to shift into the block buffer
  localparam logic [1:0] SEL_BYTE = 2'd0;
  localparam logic [1:0] SEL_MARK = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic               shift_en;
    logic [1:0]         shift_sel;
    logic               count_bits;
    logic               load_work;
    logic               round_en;
    logic [ROUND_W-1:0] round_idx;
    logic               fold;
    logic               reinit;
    logic [WIDX_W-1:0]  word_sel;
  } dp_cmd_t;

  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ src/sha256_dp.sv @@
// Datapath of the SHA-256 hasher: block buffer / schedule window, round logic,
// chaining words and bit-length counter. Depends on sha256_pkg.
module sha256_dp import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  logic [7:0] message_byte,
  output word_t      digest_word
);

  // Block buffer; bytes enter at the low end, then it serves as the schedule window.
  // Word 15 (top) is the oldest schedule word, word 0 the newest.
  logic [BLOCK_W-1:0] window;
  word_t              chain [DIGEST_WORDS];
  word_t              work  [DIGEST_WORDS];
  logic [63:0]        total_bits;

  word_t w_sched;
  word_t w_round;
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  // Message schedule and one compression round
  always_comb begin
    w_sched = small_sigma1(window[63:32]) + window[223:192]
            + small_sigma0(window[479:448]) + window[511:480];
    w_round = (cmd.round_idx[ROUND_W-1:4] == '0) ? window[511:480] : w_sched;
    ch      = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj     = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1      = work[7] + big_sigma1(work[4]) + ch + ROUND_K[cmd.round_idx] + w_round;
    t2      = big_sigma0(work[0]) + maj;
  end

  // Shift bytes in, or roll the schedule during rounds
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      case (cmd.shift_sel)
        SEL_BYTE: window <= {window[BLOCK_W-9:0], message_byte};
        SEL_MARK: window <= {window[BLOCK_W-9:0], PAD_MARK};
        SEL_ZERO: window <= {window[BLOCK_W-9:0], 8'h00};
        default:  window <= {window[BLOCK_W-65:0], total_bits};
      endcase
    end else if (cmd.round_en) begin
      window <= {window[BLOCK_W-33:0], w_round};
    end
  end

  // Count message bits; wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      total_bits <= '0;
    end else if (cmd.shift_en && cmd.count_bits) begin
      total_bits <= total_bits + 64'd8;
    end
  end

  // Working words a..h
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        work[k] <= chain[k];
      end
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  // Chaining words: fold in after each block, restart from the initial values
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        chain[k] <= INIT_H[k];
      end
    end else if (cmd.fold) begin
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        chain[k] <= chain[k] + work[k];
      end
    end
  end

  assign digest_word = chain[cmd.word_sel];

endmodule

@@ src/sha256_ctrl.sv @@
// Controller of the SHA-256 hasher: input/output handshakes, byte count, padding
// sequence, round counter and digest readout. Depends on sha256_pkg.
module sha256_ctrl import sha256_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WIDX_W-1:0] word_index,
  output logic              last_word,
  output dp_cmd_t           cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [ROUND_W-1:0] round, round_next;
  logic [WIDX_W-1:0]  word_idx, word_idx_next;
  logic               pad_active, pad_active_next;
  logic               len_done, len_done_next;

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    count_next      = count;
    round_next      = round;
    word_idx_next   = word_idx;
    pad_active_next = pad_active;
    len_done_next   = len_done;
    cmd             = '0;
    cmd.round_idx   = round;
    cmd.word_sel    = word_idx;
    in_stall        = 1'b1;
    out_valid       = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.shift_en = 1'b1;
          if (operation == OP_ABSORB) begin
            cmd.shift_sel  = SEL_BYTE;
            cmd.count_bits = 1'b1;
          end else begin
            cmd.shift_sel   = SEL_MARK;
            pad_active_next = 1'b1;
            state_next      = S_PAD;
          end
          if (count == LAST_POS) begin
            cmd.load_work = 1'b1;
            count_next    = '0;
            state_next    = S_ROUND;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (count == LEN_POS) begin
          // append the length and close the final block
          cmd.shift_sel = SEL_LEN;
          cmd.load_work = 1'b1;
          len_done_next = 1'b1;
          count_next    = '0;
          state_next    = S_ROUND;
        end else begin
          cmd.shift_sel = SEL_ZERO;
          if (count == LAST_POS) begin
            cmd.load_work = 1'b1;
            count_next    = '0;
            state_next    = S_ROUND;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_next   = round + 1'b1;
        if (round == ROUND_LAST) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (len_done) begin
          word_idx_next = '0;
          state_next    = S_OUT;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (word_idx == WIDX_LAST) begin
            cmd.reinit      = 1'b1;
            pad_active_next = 1'b0;
            len_done_next   = 1'b0;
            state_next      = S_IDLE;
          end else begin
            word_idx_next = word_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      round      <= '0;
      word_idx   <= '0;
      pad_active <= 1'b0;
      len_done   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      round      <= round_next;
      word_idx   <= word_idx_next;
      pad_active <= pad_active_next;
      len_done   <= len_done_next;
    end
  end

  assign word_index = word_idx;
  assign last_word  = (word_idx == WIDX_LAST);

  // Checks on the sequencing
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == ROUND_LAST) |=> (state == S_FOLD && round == '0))
    else $error("compression did not end after the last round");

  a_len_at_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_en && cmd.shift_sel == SEL_LEN) |-> (count == LEN_POS && pad_active))
    else $error("length inserted at the wrong byte position");

  a_len_needs_pad: assert property (@(posedge clk) disable iff (rst)
    len_done |-> pad_active)
    else $error("length inserted outside padding");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> (state == S_IDLE && count == '0 && !pad_active))
    else $error("block not restarted after the last digest word");

endmodule

@@ src/sha256_byte_stream_hasher.sv @@
// SHA-256 byte-stream hasher, top level. An absorb transaction shifts in one byte;
// every 64th byte then starts a compression (64 rounds on one shared round unit, then
// the chaining fold), during which input is stalled. Finish transaction: padding shifts
// one zero byte a cycle and the 64-bit length in one shift, then one or two compressions,
// then 8 digest words, one per unstalled cycle.
// Synchronous active-high reset loads the initial hash values and clears all counters.
module sha256_byte_stream_hasher import sha256_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [7:0]        message_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output word_t             digest_word,
  output logic [WIDX_W-1:0] word_index,
  output logic              last_word
);

  dp_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_byte (message_byte),
    .digest_word  (digest_word)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for sha256_byte_stream_hasher: streams messages byte by byte,
// predicts every digest word with its own SHA-256 model and checks each output transaction.
// Depends on sha256_pkg (word_t, operation codes, word index width) and the top level.
module tb_top;
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 250;
  localparam int MAX_REPORTS    = 10;

  // FIPS 180-4 round constants and initial hash, kept apart from the RTL tables
  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam word_t SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    word_t             digest_word;
    logic [WIDX_W-1:0] word_index;
    logic              last_word;
  } digest_entry_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              operation = OP_ABSORB;
  logic [7:0]        message_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             digest_word;
  logic [WIDX_W-1:0] word_index;
  logic              last_word;

  // Predictor state
  word_t       hash_state [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  fill_count;
  logic [63:0] bit_length;

  digest_entry_t digest_queue [$];
  int  mismatch_count = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  sha256_byte_stream_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .message_byte (message_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t rot_right(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one 64-round compression over msg_block and fold into the hash state
  function automatic void compress_block();
    word_t sched [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25)) +
           ((e & f) ^ (~e & g)) + SHA_K[t] + sched[t];
      t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22)) +
           ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_message();
    hash_state = SHA_H0;
    fill_count = '0;
    bit_length = '0;
  endfunction

  // Absorb a byte, or pad the message and queue the eight digest words
  function automatic void predict_digest(input logic op, input logic [7:0] data);
    int pos;
    digest_entry_t entry;
    if (op == OP_ABSORB) begin
      msg_block[fill_count] = data;
      if (fill_count == 6'd63) begin
        compress_block();
        bit_length += 64'd512;
      end
      fill_count = fill_count + 6'd1;
      return;
    end
    // The length field wraps modulo 2^64; far beyond reach in simulation
    bit_length += 64'(fill_count) << 3;
    pos = fill_count;
    msg_block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) begin
      msg_block[56 + k] = bit_length[63 - 8*k -: 8];
    end
    compress_block();
    for (int k = 0; k < 8; k++) begin
      entry.digest_word = hash_state[k];
      entry.word_index  = WIDX_W'(k);
      entry.last_word   = (k == 7);
      digest_queue.push_back(entry);
    end
    restart_message();
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Check each output transaction against the oldest queued digest word
  always @(posedge clk) begin
    digest_entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        note_failure($sformatf("unexpected digest word %h index %0d last %0b",
                               digest_word, word_index, last_word));
      end else begin
        want = digest_queue.pop_front();
        if (digest_word !== want.digest_word || word_index !== want.word_index ||
            last_word !== want.last_word) begin
          note_failure($sformatf("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 want.digest_word, want.word_index, want.last_word,
                                 digest_word, word_index, last_word));
        end
      end
    end
  end

  // Stall the output in random bursts while idling is enabled
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run if neither side moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one input transaction; returns at the accepting rising edge
  task automatic send_item(input logic op, input logic [7:0] data);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    message_byte <= data;
    predict_digest(op, data);
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (digest_queue.size() != 0) @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 7))
      0:       return 0;
      5:       return $urandom_range(50, 70);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // Empty message straight after reset, then again back to back
  task automatic test_empty_message();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hff);
  endtask

  task automatic test_short_message();
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
  endtask

  // Byte extremes, a byte equal to the pad marker, and junk on the finish byte
  task automatic test_byte_extremes();
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_FINISH, 8'hff);
  endtask

  // Lengths either side of the spill into an extra padding block and a full block
  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
  endtask

  task automatic test_random_messages();
    int start;
    start = items_sent;
    while (items_sent - start < 70) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_message(pick_length());
    end
    idle_on = 1'b1;
  endtask

  // Hold the sender until every digest word has come out
  task automatic test_drain_pause();
    send_message($urandom_range(3, 10));
    end_burst();
    wait_for_drain();
    send_message($urandom_range(3, 10));
    end_burst();
    wait_for_drain();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream();
    int start;
    idle_on = 1'b0;
    start = items_sent;
    while (items_sent - start < 30) begin
      send_message($urandom_range(0, 12));
    end
  endtask

  initial begin
    restart_message();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_short_message();
    test_byte_extremes();
    test_block_boundaries();
    test_random_messages();
    test_drain_pause();
    test_steady_stream();
    end_burst();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
